// File: design/erdd_pkg.sv
// Package for the edge-rate deviation detector.
// Shared constants, sequencer state and micro-op codes; no dependencies.

package erdd_pkg;

    // Calibration lengths in samples
    localparam logic [3:0] METAL_CAL_SAMPLES = 4'd12;
    localparam logic [4:0] CARD_CAL_SAMPLES  = 5'd24;

    // Q0.16 smoothing coefficients
    localparam logic [21:0] A_METAL_CAL = 22'd16384;  // 0.25
    localparam logic [21:0] A_CARD_CAL  = 22'd9830;   // 0.15
    localparam logic [21:0] A_DRIFT     = 22'd2621;   // 0.04
    localparam logic [21:0] A_DEV       = 22'd19661;  // 0.30

    // level = floor(avg * 2 / 375) = (avg * LEVEL_RECIP) >> 29, exact below LEVEL_SAT_AVG
    localparam logic [21:0] LEVEL_RECIP   = 22'd2863312;
    localparam int          LEVEL_SHIFT   = 29;
    localparam logic [25:0] LEVEL_SAT_AVG = 26'd768000;
    localparam logic [12:0] LEVEL_FULL    = 13'd4096;

    // Card presence thresholds on the Q0.12 level
    localparam logic [12:0] FOUND_LEVEL = 13'd205;
    localparam logic [12:0] LOST_LEVEL  = 13'd102;

    // Register reset values
    localparam logic [3:0]  SENSITIVITY_RESET = 4'd4;
    localparam logic [15:0] HOLD_MS_RESET     = 16'd350;

    // Configuration register indexes
    localparam logic [1:0] CFG_SENSITIVITY = 2'd0;
    localparam logic [1:0] CFG_CARD_MODE   = 2'd1;
    localparam logic [1:0] CFG_HOLD_MS     = 2'd2;

    // Input commands
    localparam logic [1:0] CMD_SAMPLE       = 2'd0;
    localparam logic [1:0] CMD_METAL_RESTART = 2'd1;
    localparam logic [1:0] CMD_CARD_RESTART  = 2'd2;
    localparam logic [1:0] CMD_CARD_CLEAR    = 2'd3;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIFF  = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_WRITE = 6'b001000,
        ST_TRACK = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    // Micro-ops run on the shared subtract / multiply / apply unit
    typedef enum logic [2:0] {
        OP_MBASE = 3'd0,
        OP_MDEV  = 3'd1,
        OP_MAVG  = 3'd2,
        OP_CBASE = 3'd3,
        OP_CDEV  = 3'd4,
        OP_CAVG  = 3'd5,
        OP_CLVL  = 3'd6,
        OP_MLVL  = 3'd7
    } op_t;

endpackage

// File: design/edge_rate_deviation_detector_core.sv
// Edge-rate deviation detector, top level.
// Uses erdd_pkg; one shared multiplier driven by a small micro-op sequencer.
//
// Usage
//   Input channel (in_valid / in_stall): one word carries command, edge_count
//   and time_ms. in_stall is high while a word is being worked on or its result
//   waits, so one word is in flight at a time.
//   Output channel (out_valid / out_stall): one result word per input word.
//   Configuration port (cfg_valid / cfg_ready, cfg_index, cfg_data): always
//   ready; write only while idle. Index 0 sensitivity, 1 card_mode, 2 hold_ms.
// Sequencing
//   Every word runs n micro-ops, each a difference, a multiply and an apply
//   step through the one shared multiplier: n = 2 for the restart and
//   clear commands (the two level conversions), up to 7 for a sample with
//   metal drift and card tracking, plus a presence update when tracking.
//   out_valid rises once the last micro-op is applied; the next word is
//   taken only after the result has been taken.
// Reset
//   Control and detector state clears, datapath registers do not; registers
//   return to sensitivity 4, card_mode 0, hold_ms 350.
// Stall
//   While out_stall is high the result word holds and no input is taken.

module edge_rate_deviation_detector_core
    import erdd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [31:0] edge_count,
    input  logic [31:0] time_ms,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [12:0] metal_level,
    output logic [12:0] card_level,
    output logic        metal_calibrating,
    output logic        card_ready,
    output logic        card_present,
    output logic        card_alert,
    // configuration port
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // ---------------- control state ----------------
    state_t      state_reg, state_next;
    op_t         op_reg, op_next;
    logic        track_reg, track_next;     // card tracker runs on this sample
    logic        alert_reg, alert_next;

    // configuration
    logic [3:0]  sens_reg;
    logic        card_mode_reg;
    logic [15:0] hold_reg;

    // detector state
    logic [31:0] prev_count_reg, prev_count_next;
    logic [23:0] mbase_reg, mbase_next;
    logic [25:0] mavg_reg, mavg_next;
    logic [3:0]  mframes_reg, mframes_next;
    logic [23:0] cbase_reg, cbase_next;
    logic [25:0] cavg_reg, cavg_next;
    logic [4:0]  cframes_reg, cframes_next;
    logic        ccal_reg, ccal_next;
    logic        found_reg, found_next;
    logic [31:0] since_reg, since_next;
    logic        alerted_reg, alerted_next;

    // ---------------- datapath registers (no reset) ----------------
    logic [23:0] x_reg, x_next;             // Q16.8 target of this sample
    logic [31:0] now_reg, now_next;
    logic [25:0] mag_reg, mag_next;
    logic        neg_reg, neg_next;
    logic [47:0] prod_reg, prod_next;
    logic [25:0] dev_reg, dev_next;         // scaled deviation, Q18.8
    logic [12:0] mlevel_reg, mlevel_next;
    logic [12:0] clevel_reg, clevel_next;

    // ---------------- shared unit ----------------
    logic [25:0] old_op, tgt_op;
    logic [21:0] coef_sel;
    logic [26:0] ema_inc;
    logic [25:0] ema_res;
    logic [12:0] lvl_res;
    logic [25:0] lvl_avg;
    logic        metal_cal;
    logic        card_learning;
    logic [31:0] delta_raw;
    logic [15:0] delta_sat;
    logic [4:0]  cframes_inc;
    logic [31:0] held_ms;
    logic        accept_in;

    assign metal_cal     = (mframes_reg < METAL_CAL_SAMPLES);
    assign card_learning = (cframes_reg < CARD_CAL_SAMPLES);
    assign accept_in     = in_valid && !in_stall;

    assign delta_raw = edge_count - prev_count_reg;
    assign delta_sat = (|delta_raw[31:16]) ? 16'hFFFF : delta_raw[15:0];

    // operand selection: old value and target of the current micro-op
    always_comb
    begin
        unique case (op_reg)
            OP_MBASE, OP_MDEV:
            begin
                old_op = {2'b00, mbase_reg};
                tgt_op = {2'b00, x_reg};
            end
            OP_CBASE, OP_CDEV:
            begin
                old_op = {2'b00, cbase_reg};
                tgt_op = {2'b00, x_reg};
            end
            OP_MAVG:
            begin
                old_op = mavg_reg;
                tgt_op = dev_reg;
            end
            OP_CAVG:
            begin
                old_op = cavg_reg;
                tgt_op = dev_reg;
            end
            OP_MLVL:
            begin
                old_op = '0;
                tgt_op = mavg_reg;
            end
            OP_CLVL:
            begin
                old_op = '0;
                tgt_op = cavg_reg;
            end
        endcase
    end

    always_comb
    begin
        unique case (op_reg)
            OP_MBASE:         coef_sel = metal_cal ? A_METAL_CAL : A_DRIFT;
            OP_CBASE:         coef_sel = A_CARD_CAL;
            OP_MDEV, OP_CDEV: coef_sel = {18'd0, sens_reg};
            OP_MAVG, OP_CAVG: coef_sel = A_DEV;
            OP_MLVL, OP_CLVL: coef_sel = LEVEL_RECIP;
        endcase
    end

    // rounded step, half away from zero: (|d| * A + 2^15) >> 16
    assign ema_inc = prod_reg[42:16] + {26'd0, prod_reg[15]};
    assign ema_res = neg_reg ? (old_op - ema_inc[25:0]) : (old_op + ema_inc[25:0]);

    assign lvl_avg = (op_reg == OP_MLVL) ? mavg_reg : cavg_reg;
    assign lvl_res = (lvl_avg >= LEVEL_SAT_AVG) ? LEVEL_FULL
                   : {1'b0, prod_reg[LEVEL_SHIFT +: 12]};

    assign cframes_inc = cframes_reg + 5'd1;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        track_next      = track_reg;
        alert_next      = alert_reg;
        prev_count_next = prev_count_reg;
        mbase_next      = mbase_reg;
        mavg_next       = mavg_reg;
        mframes_next    = mframes_reg;
        cbase_next      = cbase_reg;
        cavg_next       = cavg_reg;
        cframes_next    = cframes_reg;
        ccal_next       = ccal_reg;
        found_next      = found_reg;
        since_next      = since_reg;
        alerted_next    = alerted_reg;
        x_next          = x_reg;
        now_next        = now_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        prod_next       = prod_reg;
        dev_next        = dev_reg;
        mlevel_next     = mlevel_reg;
        clevel_next     = clevel_reg;
        held_ms         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    alert_next = 1'b0;
                    track_next = 1'b0;
                    now_next   = time_ms;
                    state_next = ST_DIFF;
                    op_next    = OP_CLVL;
                    unique case (command)
                        CMD_SAMPLE:
                        begin
                            prev_count_next = edge_count;
                            x_next          = {delta_sat, 8'h00};
                            op_next         = OP_MBASE;
                        end
                        CMD_METAL_RESTART:
                        begin
                            mframes_next = '0;
                            mbase_next   = '0;
                            mavg_next    = '0;
                        end
                        CMD_CARD_RESTART:
                        begin
                            cframes_next = '0;
                            cbase_next   = '0;
                            cavg_next    = '0;
                            ccal_next    = 1'b0;
                            found_next   = 1'b0;
                            since_next   = '0;
                            alerted_next = 1'b0;
                        end
                        CMD_CARD_CLEAR:
                        begin
                            found_next   = 1'b0;
                            since_next   = '0;
                            alerted_next = 1'b0;
                        end
                    endcase
                end
            end

            ST_DIFF:
            begin
                neg_next   = (tgt_op < old_op);
                mag_next   = (tgt_op < old_op) ? (old_op - tgt_op) : (tgt_op - old_op);
                state_next = ST_MUL;
            end

            ST_MUL:
            begin
                prod_next  = 48'(mag_reg) * 48'(coef_sel);
                state_next = ST_WRITE;
            end

            ST_WRITE:
            begin
                state_next = ST_DIFF;
                unique case (op_reg)
                    OP_MBASE:
                    begin
                        if (metal_cal)
                        begin
                            mbase_next   = (mframes_reg == '0) ? x_reg : ema_res[23:0];
                            mframes_next = mframes_reg + 4'd1;
                            mavg_next    = '0;
                        end
                        else
                        begin
                            mbase_next = ema_res[23:0];
                        end
                        // card branch follows calibration, deviation follows drift
                        if (!metal_cal)
                            op_next = OP_MDEV;
                        else if (!card_mode_reg)
                            op_next = OP_CLVL;
                        else if (card_learning)
                            op_next = OP_CBASE;
                        else
                        begin
                            op_next    = OP_CDEV;
                            track_next = 1'b1;
                        end
                    end
                    OP_MDEV:
                    begin
                        dev_next = prod_reg[27:2];
                        op_next  = OP_MAVG;
                    end
                    OP_MAVG:
                    begin
                        mavg_next = ema_res;
                        if (!card_mode_reg)
                            op_next = OP_CLVL;
                        else if (card_learning)
                            op_next = OP_CBASE;
                        else
                        begin
                            op_next    = OP_CDEV;
                            track_next = 1'b1;
                        end
                    end
                    OP_CBASE:
                    begin
                        cbase_next   = (cframes_reg == '0) ? x_reg : ema_res[23:0];
                        cframes_next = cframes_inc;
                        if (cframes_inc >= CARD_CAL_SAMPLES)
                            ccal_next = 1'b1;
                        op_next = OP_CLVL;
                    end
                    OP_CDEV:
                    begin
                        dev_next = prod_reg[27:2];
                        op_next  = OP_CAVG;
                    end
                    OP_CAVG:
                    begin
                        cavg_next = ema_res;
                        op_next   = OP_CLVL;
                    end
                    OP_CLVL:
                    begin
                        clevel_next = lvl_res;
                        op_next     = OP_MLVL;
                        if (track_reg)
                            state_next = ST_TRACK;
                    end
                    OP_MLVL:
                    begin
                        mlevel_next = lvl_res;
                        state_next  = ST_OUT;
                    end
                endcase
            end

            ST_TRACK:
            begin
                // hysteresis on the fresh card level, then the hold timer
                if (clevel_reg >= FOUND_LEVEL)
                begin
                    if (!found_reg)
                    begin
                        found_next   = 1'b1;
                        since_next   = now_reg;
                        alerted_next = 1'b0;
                    end
                end
                else if (clevel_reg < LOST_LEVEL)
                begin
                    found_next   = 1'b0;
                    alerted_next = 1'b0;
                end
                held_ms = now_reg - since_next;
                if (found_next && !alerted_next && (held_ms >= {16'd0, hold_reg}))
                begin
                    alerted_next = 1'b1;
                    alert_next   = 1'b1;
                end
                state_next = ST_DIFF;
            end

            ST_OUT:
            begin
                if (!out_stall)
                    state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= OP_MBASE;
            track_reg      <= 1'b0;
            alert_reg      <= 1'b0;
            prev_count_reg <= '0;
            mbase_reg      <= '0;
            mavg_reg       <= '0;
            mframes_reg    <= '0;
            cbase_reg      <= '0;
            cavg_reg       <= '0;
            cframes_reg    <= '0;
            ccal_reg       <= 1'b0;
            found_reg      <= 1'b0;
            since_reg      <= '0;
            alerted_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            track_reg      <= track_next;
            alert_reg      <= alert_next;
            prev_count_reg <= prev_count_next;
            mbase_reg      <= mbase_next;
            mavg_reg       <= mavg_next;
            mframes_reg    <= mframes_next;
            cbase_reg      <= cbase_next;
            cavg_reg       <= cavg_next;
            cframes_reg    <= cframes_next;
            ccal_reg       <= ccal_next;
            found_reg      <= found_next;
            since_reg      <= since_next;
            alerted_reg    <= alerted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        now_reg    <= now_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        prod_reg   <= prod_next;
        dev_reg    <= dev_next;
        mlevel_reg <= mlevel_next;
        clevel_reg <= clevel_next;
    end

    // configuration registers; unknown indexes are ignored
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_reg      <= SENSITIVITY_RESET;
            card_mode_reg <= 1'b0;
            hold_reg      <= HOLD_MS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SENSITIVITY: sens_reg      <= cfg_data[3:0];
                CFG_CARD_MODE:   card_mode_reg <= cfg_data[0];
                CFG_HOLD_MS:     hold_reg      <= cfg_data;
                default:         ;
            endcase
        end
    end

    // ---------------- ports ----------------
    assign in_stall          = (state_reg != ST_IDLE);
    assign out_valid         = (state_reg == ST_OUT);
    assign metal_level       = mlevel_reg;
    assign card_level        = clevel_reg;
    assign metal_calibrating = metal_cal;
    assign card_ready        = ccal_reg;
    assign card_present      = found_reg;
    assign card_alert        = alert_reg;

endmodule

// File: design/erdd_checker.sv
// Port-level checks for the edge-rate deviation detector.
// Bound to edge_rate_deviation_detector_core; no package needed.

module erdd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic [12:0] metal_level,
    input logic        metal_calibrating,
    input logic        card_ready,
    input logic        card_present,
    input logic        card_alert
);

    // one word in flight: a pending result blocks the input
    a_busy_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while a result word is pending");

    // a result never appears in the cycle straight after acceptance
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !out_valid)
        else $error("result word too early after acceptance");

    // an alert needs a present, calibrated card
    a_alert_needs_card: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && card_alert) |-> (card_present && card_ready))
        else $error("alert without present calibrated card");

    // metal deviation is held at zero during calibration
    a_cal_level_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && metal_calibrating) |-> (metal_level == 13'd0))
        else $error("metal level non-zero while calibrating");

endmodule

bind edge_rate_deviation_detector_core erdd_checker u_erdd_checker (.*);
